FILE: rtl/core/assert_macros.svh
// Assertion macros used by the watchdog datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is asserted.
`define WLW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked check that also holds during reset.
`define WLW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/wlw_pkg.sv
// Package: widths, register indexes, FSM states and control structs of the watchdog.
`timescale 1ns / 1ps

package wlw_pkg;

  // History depth
  localparam int MAX_WINDOW = 64;

  // Field widths
  localparam int MS_W    = 16;
  localparam int WIN_W   = 7;
  localparam int TIMER_W = 17;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 16;
  localparam int IN_W    = 16;
  localparam int OUT_W   = 40;

  // Derived widths
  localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int FILL_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = MS_W + FILL_W;
  localparam int DCNT_W = $clog2(SUM_W + 1);

  localparam logic [TIMER_W-1:0] TIMER_MAX    = '1;
  localparam logic [MS_W-1:0]    INTERVAL_RST = 16'd1000;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] REG_MONITOR_ENABLE = 3'd0;
  localparam logic [CFG_AW-1:0] REG_REBOOT_WINDOW  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_ALERT_WINDOW   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_ABNORMAL_LIMIT = 3'd3;
  localparam logic [CFG_AW-1:0] REG_REBOOT_INTVL   = 3'd4;
  localparam logic [CFG_AW-1:0] REG_ALERT_INTVL    = 3'd5;

  // Checker select
  localparam logic SEL_REBOOT = 1'b0;
  localparam logic SEL_ALERT  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SUM,
    ST_DIV,
    ST_STORE
  } wlw_state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;      // latch item, advance timers
    logic sel;         // checker being averaged
    logic walk_start;  // reset history walk
    logic walk;        // walk history one entry
    logic div_start;   // load divider from sum
    logic div_step;    // one quotient bit
    logic save_avg;    // keep quotient as checker average
    logic emit;        // load result, push duration
  } wlw_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_rb;
    logic need_al;
    logic walk_done;
    logic div_done;
    logic out_free;
  } wlw_status_t;

endpackage

FILE: rtl/core/wlw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module wlw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/wlw_ctrl.sv
// Controller FSM: sequences accept, window walks, divides and result emission.
`timescale 1ns / 1ps

module wlw_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  wlw_pkg::wlw_status_t sts,
  output wlw_pkg::wlw_cmd_t    cmd
);

  wlw_pkg::wlw_state_t state_r, state_nxt;
  logic                sel_r, sel_nxt;
  logic                need_cur;

  assign need_cur = (sel_r == wlw_pkg::SEL_ALERT) ? sts.need_al : sts.need_rb;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wlw_pkg::ST_IDLE;
      sel_r   <= wlw_pkg::SEL_REBOOT;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    unique case (state_r)
      wlw_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = wlw_pkg::ST_CHECK;
          sel_nxt   = wlw_pkg::SEL_REBOOT;
        end
      end
      wlw_pkg::ST_CHECK: begin
        if (need_cur) begin
          state_nxt = wlw_pkg::ST_SUM;
        end else if (sel_r == wlw_pkg::SEL_ALERT) begin
          state_nxt = wlw_pkg::ST_STORE;
        end else begin
          sel_nxt = wlw_pkg::SEL_ALERT;
        end
      end
      wlw_pkg::ST_SUM: begin
        if (sts.walk_done) begin
          state_nxt = wlw_pkg::ST_DIV;
        end
      end
      wlw_pkg::ST_DIV: begin
        if (sts.div_done) begin
          if (sel_r == wlw_pkg::SEL_REBOOT) begin
            sel_nxt   = wlw_pkg::SEL_ALERT;
            state_nxt = wlw_pkg::ST_CHECK;
          end else begin
            state_nxt = wlw_pkg::ST_STORE;
          end
        end
      end
      wlw_pkg::ST_STORE: begin
        if (sts.out_free) begin
          state_nxt = wlw_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wlw_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd       = '0;
    cmd.sel   = sel_r;
    in_tready = 1'b0;
    unique case (state_r)
      wlw_pkg::ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      wlw_pkg::ST_CHECK: begin
        cmd.walk_start = need_cur;
      end
      wlw_pkg::ST_SUM: begin
        cmd.walk      = 1'b1;
        cmd.div_start = sts.walk_done;
      end
      wlw_pkg::ST_DIV: begin
        cmd.div_step = !sts.div_done;
        cmd.save_avg = sts.div_done;
      end
      wlw_pkg::ST_STORE: begin
        cmd.emit = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

FILE: rtl/core/wlw_datapath.sv
// Datapath: config registers, timers, history ring, window sum, divider, result register.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module wlw_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [wlw_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [wlw_pkg::CFG_DW-1:0]    cfg_wdata,
  input  logic [wlw_pkg::MS_W-1:0]      in_loop_ms,
  input  wlw_pkg::wlw_cmd_t             cmd,
  output wlw_pkg::wlw_status_t          sts,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [wlw_pkg::OUT_W-1:0]     out_tdata
);

  localparam int MS_W    = wlw_pkg::MS_W;
  localparam int WIN_W   = wlw_pkg::WIN_W;
  localparam int TIMER_W = wlw_pkg::TIMER_W;
  localparam int PTR_W   = wlw_pkg::PTR_W;
  localparam int FILL_W  = wlw_pkg::FILL_W;
  localparam int SUM_W   = wlw_pkg::SUM_W;
  localparam int DCNT_W  = wlw_pkg::DCNT_W;
  localparam int PAD_W   = wlw_pkg::OUT_W - 2 - 2 * MS_W;

  // Configuration registers
  logic               mon_en_r;
  logic [WIN_W-1:0]   rb_win_r, al_win_r;
  logic [MS_W-1:0]    limit_r, rb_int_r, al_int_r;

  // Item state
  logic [MS_W-1:0]    loop_r;
  logic               en_r;
  logic               need_rb_r, need_al_r;
  logic [TIMER_W-1:0] rb_timer_r, al_timer_r;
  logic               latched_r;
  logic [PTR_W-1:0]   head_r;
  logic [FILL_W-1:0]  fill_r;
  logic [MS_W-1:0]    rb_avg_r, al_avg_r;

  // Walk and divider
  logic [WIN_W-1:0]   cnt_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic               pend_r;
  logic [SUM_W-1:0]   sum_r;
  logic [SUM_W-1:0]   quo_r;
  logic [WIN_W-1:0]   rem_r;
  logic [DCNT_W-1:0]  dcnt_r;

  // Result register
  logic                     out_valid_r;
  logic [wlw_pkg::OUT_W-1:0] out_data_r;

  logic [MS_W-1:0]    rd_data;

  // Config write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mon_en_r <= 1'b0;
      rb_win_r <= '0;
      al_win_r <= '0;
      limit_r  <= '0;
      rb_int_r <= wlw_pkg::INTERVAL_RST;
      al_int_r <= wlw_pkg::INTERVAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        wlw_pkg::REG_MONITOR_ENABLE: mon_en_r <= cfg_wdata[0];
        wlw_pkg::REG_REBOOT_WINDOW:  rb_win_r <= cfg_wdata[WIN_W-1:0];
        wlw_pkg::REG_ALERT_WINDOW:   al_win_r <= cfg_wdata[WIN_W-1:0];
        wlw_pkg::REG_ABNORMAL_LIMIT: limit_r  <= cfg_wdata[MS_W-1:0];
        wlw_pkg::REG_REBOOT_INTVL:   rb_int_r <= cfg_wdata[MS_W-1:0];
        wlw_pkg::REG_ALERT_INTVL:    al_int_r <= cfg_wdata[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // Timer advance and check decision for both checkers
  logic               rb_en, al_en;
  logic [TIMER_W:0]   rb_add, al_add;
  logic [TIMER_W-1:0] rb_t, al_t;
  logic               rb_fire, al_fire;
  logic               rb_fits, al_fits;

  always_comb begin
    rb_en   = (rb_win_r != '0) && (limit_r != '0);
    al_en   = (al_win_r != '0) && (limit_r != '0);
    rb_add  = {1'b0, rb_timer_r} + (TIMER_W + 1)'(in_loop_ms);
    al_add  = {1'b0, al_timer_r} + (TIMER_W + 1)'(in_loop_ms);
    rb_t    = rb_add[TIMER_W] ? wlw_pkg::TIMER_MAX : rb_add[TIMER_W-1:0];
    al_t    = al_add[TIMER_W] ? wlw_pkg::TIMER_MAX : al_add[TIMER_W-1:0];
    rb_fire = rb_en && (rb_t >= TIMER_W'(rb_int_r));
    al_fire = al_en && (al_t >= TIMER_W'(al_int_r));
    rb_fits = 32'(rb_win_r) <= 32'(fill_r);
    al_fits = 32'(al_win_r) <= 32'(fill_r);
  end

  // Accept: latch item, advance timers, decide which averages are needed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rb_timer_r <= '0;
      al_timer_r <= '0;
      need_rb_r  <= 1'b0;
      need_al_r  <= 1'b0;
      en_r       <= 1'b0;
    end else if (cmd.accept) begin
      en_r      <= mon_en_r;
      need_rb_r <= mon_en_r && rb_fire && rb_fits;
      need_al_r <= mon_en_r && al_fire && al_fits;
      if (mon_en_r && rb_en) begin
        rb_timer_r <= rb_fire ? '0 : rb_t;
      end
      if (mon_en_r && al_en) begin
        al_timer_r <= al_fire ? '0 : al_t;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      loop_r <= in_loop_ms;
    end
  end

  // Window walk: newest entry first, one read issued per cycle
  logic [WIN_W-1:0] win_sel;
  logic             issue;
  logic [PTR_W-1:0] head_prev, rd_ptr_prev, head_next;

  always_comb begin
    win_sel     = (cmd.sel == wlw_pkg::SEL_ALERT) ? al_win_r : rb_win_r;
    issue       = cmd.walk && (cnt_r != win_sel);
    head_prev   = (head_r == '0) ? PTR_W'(wlw_pkg::MAX_WINDOW - 1) : head_r - 1'b1;
    rd_ptr_prev = (rd_ptr_r == '0) ? PTR_W'(wlw_pkg::MAX_WINDOW - 1) : rd_ptr_r - 1'b1;
    head_next   = (head_r == PTR_W'(wlw_pkg::MAX_WINDOW - 1)) ? '0 : head_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else if (cmd.walk_start) begin
      pend_r <= 1'b0;
    end else if (cmd.walk) begin
      pend_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      cnt_r    <= '0;
      rd_ptr_r <= head_prev;
      sum_r    <= '0;
    end else if (cmd.walk) begin
      if (issue) begin
        cnt_r    <= cnt_r + 1'b1;
        rd_ptr_r <= rd_ptr_prev;
      end
      if (pend_r) begin
        sum_r <= sum_r + SUM_W'(rd_data);
      end
    end
  end

  // Restoring divider, one quotient bit per step
  logic [WIN_W:0]   trial, trial_diff;
  logic             trial_ge;

  always_comb begin
    trial      = {rem_r, quo_r[SUM_W-1]};
    trial_ge   = trial >= {1'b0, win_sel};
    trial_diff = trial - {1'b0, win_sel};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.div_start) begin
      dcnt_r <= DCNT_W'(SUM_W);
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo_r <= sum_r;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[SUM_W-2:0], trial_ge};
      rem_r <= trial_ge ? trial_diff[WIN_W-1:0] : trial[WIN_W-1:0];
    end
  end

  // Averages of this item
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rb_avg_r <= '0;
      al_avg_r <= '0;
    end else if (cmd.save_avg) begin
      if (cmd.sel == wlw_pkg::SEL_ALERT) begin
        al_avg_r <= quo_r[MS_W-1:0];
      end else begin
        rb_avg_r <= quo_r[MS_W-1:0];
      end
    end
  end

  // Verdicts
  logic req, alert;

  always_comb begin
    req   = (rb_avg_r != '0) && (rb_avg_r >= limit_r) && !latched_r;
    alert = (al_avg_r != '0) && (al_avg_r >= limit_r);
  end

  // Emit: sticky latch, history push
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latched_r <= 1'b0;
      head_r    <= '0;
      fill_r    <= '0;
    end else if (cmd.emit) begin
      if (req) begin
        latched_r <= 1'b1;
      end
      if (en_r) begin
        head_r <= head_next;
        if (fill_r != FILL_W'(wlw_pkg::MAX_WINDOW)) begin
          fill_r <= fill_r + 1'b1;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= {{PAD_W{1'b0}}, al_avg_r, rb_avg_r, alert, req};
    end
  end

  // History ring
  wlw_ram #(
    .WIDTH (MS_W),
    .DEPTH (wlw_pkg::MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.emit && en_r),
    .waddr (head_r),
    .wdata (loop_r),
    .re    (issue),
    .raddr (rd_ptr_r),
    .rdata (rd_data)
  );

  // Status
  always_comb begin
    sts.need_rb   = need_rb_r;
    sts.need_al   = need_al_r;
    sts.walk_done = (cnt_r == win_sel) && !pend_r;
    sts.div_done  = (dcnt_r == '0);
    sts.out_free  = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Checks
  `WLW_ASSERT(a_latch_reported, clk, rst_n, $rose(latched_r) |-> out_valid_r && out_data_r[0], "reboot latch set without a reported request")
  `WLW_ASSERT(a_div_nonzero, clk, rst_n, cmd.div_start |-> win_sel != '0, "divide started with a zero window")
  `WLW_ASSERT(a_head_tracks_fill, clk, rst_n, (32'(fill_r) < wlw_pkg::MAX_WINDOW) |-> (32'(head_r) == 32'(fill_r)), "ring head and fill count disagree before the ring is full")

endmodule

FILE: rtl/core/windowed_lag_watchdog.sv
// Top level of the loop duration watchdog: controller plus datapath.
`timescale 1ns / 1ps

// Usage:
// - in_*: one item per finished loop, in_tdata[15:0] = loop duration in ms.
// - out_*: exactly one result item per input item, in input order.
// - cfg_*: write-only registers 0..5 (enable, reboot window, alert window,
//   abnormal limit, reboot interval, alert interval); write only while idle.
// - Sequencing: when no check fires, an accepted item passes through the reboot
//   and alert checks and STORE; the controller is back in idle, ready for the
//   next item, at the edge that raises out_tvalid. Each check that fires adds
//   a walk, one RAM read per stored duration on the single history read port,
//   then a 23-step bit-serial divide plus a step to keep the quotient.
// - Items are processed one at a time; in_tready is high only while idle.
// - A finished result sits in an output register; the next item is accepted
//   while it waits, and that item stalls before emission until the receiver
//   takes the pending result.
// - Reset (rst_n low, synchronous) clears timers, history fill, the reboot
//   latch and the output valid; registers return to their reset values.
//   History RAM contents are not cleared; only written entries are read.
module windowed_lag_watchdog (
  input  logic                       clk,
  input  logic                       rst_n,
  // Config write port
  input  logic                       cfg_we,
  input  logic [wlw_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [wlw_pkg::CFG_DW-1:0] cfg_wdata,
  // Input items
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [wlw_pkg::IN_W-1:0]   in_tdata,   // [15:0] loop_ms
  // Result items
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [wlw_pkg::OUT_W-1:0]  out_tdata   // [0] reboot_request, [1] alert_raised,
                                                 // [17:2] reboot_avg_ms,
                                                 // [33:18] alert_avg_ms, [39:34] zero
);

  wlw_pkg::wlw_cmd_t    cmd;
  wlw_pkg::wlw_status_t sts;

  wlw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  wlw_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_loop_ms (in_tdata[wlw_pkg::MS_W-1:0]),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
